// ----- rtl/desa_pkg.sv -----
// Shared constants, function codes and controller command type for the
// double-ended stack allocator. No dependencies.
package desa_pkg;

  // Arena, header and record store dimensions.
  localparam int ARENA_BYTES = 65536;
  localparam int HDR_BYTES   = 8;
  localparam int MAX_RECORDS = 8192;

  // Field widths.
  localparam int OFS_W  = 17;
  localparam int FUNC_W = 3;
  localparam int IDX_W  = $clog2(MAX_RECORDS);
  localparam int REC_W  = IDX_W + 1;

  // Smallest arena that a register write may select.
  localparam int MIN_ARENA = 16;

  // Command codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_TOP    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ALLOC_BOTTOM = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FREE_TOP     = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FREE_BOTTOM  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_TOP    = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR_BOTTOM = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_PEEK         = 3'd6;

  // Register index of arena_bytes (word address bit).
  localparam logic REG_ARENA_BYTES = 1'b0;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;   // capture the command and start the header read
    logic execute;  // update the stacks and load the result register
  } cmd_t;

endpackage

// ----- rtl/double_ended_stack_allocator_top.sv -----
// Top level of the double-ended stack allocator: register port decode and
// assembly of controller and datapath. Depends on desa_pkg, desa_ctrl, desa_dp.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_stall_o   func_i, alloc_size_i
//   out       output     out_valid_o / out_stall_i ok_o, block_offset_o,
//                                                  top_block_o, bottom_block_o
//   config    input      psel/penable/pwrite       paddr, pwdata, prdata
//
// Every command reads the registered header store at capture, then does the
// stack update that needs the header size. A new command is taken only once
// the one before it has loaded the registered result.
// After reset the arena is 65536 bytes and both stacks are empty; no clearing
// pass is needed. A stalled result holds the next command in its stack update.
module double_ended_stack_allocator_top import desa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [OFS_W-1:0]  alloc_size_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              ok_o,
  output logic [OFS_W-1:0]  block_offset_o,
  output logic [OFS_W-1:0]  top_block_o,
  output logic [OFS_W-1:0]  bottom_block_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cmd_t             cmd;
  logic             cfg_we;
  logic [OFS_W-1:0] arena;

  // Register transfer decode; only the word bit of the address selects.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ARENA_BYTES);
  assign prdata = (paddr[2] == REG_ARENA_BYTES) ? {{(32-OFS_W){1'b0}}, arena} : '0;

  desa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  desa_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (func_i),
    .alloc_size_i   (alloc_size_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[OFS_W-1:0]),
    .arena_o        (arena),
    .ok_o           (ok_o),
    .block_offset_o (block_offset_o),
    .top_block_o    (top_block_o),
    .bottom_block_o (bottom_block_o)
  );

endmodule

// ----- rtl/desa_ram.sv -----
// Generic single-port RAM with a registered read port.
// No dependencies.
module desa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // At most one write and one read per cycle, at the same address; read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/desa_ctrl.sv -----
// Controller for the double-ended stack allocator: input and output
// handshakes and the two-step command sequence. Depends on desa_pkg.
module desa_ctrl import desa_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  // A transfer is taken only while idle; execution waits for room in the
  // result register, so the header read data simply holds meanwhile.
  assign out_free       = !out_valid_q || !out_stall_i;
  assign cmd_o.accept   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.execute  = (state_q == ST_EXEC) && out_free;
  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = out_valid_q;

  // Next state and result valid.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (cmd_o.execute) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/desa_dp.sv -----
// Datapath for the double-ended stack allocator: stack pointers, record
// counts, header store and result register. Depends on desa_pkg, desa_ram.
module desa_dp import desa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [FUNC_W-1:0] func_i,
  input  logic [OFS_W-1:0]  alloc_size_i,
  input  logic              cfg_we_i,
  input  logic [OFS_W-1:0]  cfg_wdata_i,
  output logic [OFS_W-1:0]  arena_o,
  output logic              ok_o,
  output logic [OFS_W-1:0]  block_offset_o,
  output logic [OFS_W-1:0]  top_block_o,
  output logic [OFS_W-1:0]  bottom_block_o
);

  localparam logic [OFS_W:0]   HDR_EXT  = (OFS_W+1)'(HDR_BYTES);
  localparam logic [OFS_W-1:0] HDR_OFS  = OFS_W'(HDR_BYTES);
  localparam logic [OFS_W-1:0] ARENA_RST = OFS_W'(ARENA_BYTES);
  localparam logic [OFS_W-1:0] ARENA_MIN = OFS_W'(MIN_ARENA);
  localparam logic [REC_W:0]   MAX_REC  = (REC_W+1)'(MAX_RECORDS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_RECORDS - 1);

  logic [OFS_W-1:0]  arena_q, arena_d;
  logic [OFS_W-1:0]  top_q, top_d;          // first free byte of the top stack
  logic [OFS_W-1:0]  bot_q, bot_d;          // lowest used byte of the bottom stack
  logic [OFS_W-1:0]  tblk_q, tblk_d;        // newest top block, valid when tr_q != 0
  logic [REC_W-1:0]  tr_q, tr_d;
  logic [REC_W-1:0]  br_q, br_d;
  logic [FUNC_W-1:0] func_q;
  logic [OFS_W-1:0]  size_q;

  logic              ok_q, ok_d;
  logic [OFS_W-1:0]  blk_q, blk_d;
  logic [OFS_W-1:0]  topb_q, botb_q;

  logic [OFS_W:0]    need;
  logic [OFS_W-1:0]  gap;
  logic              room, fits_top, fits_bot;
  logic [REC_W:0]    rec_sum;
  logic [REC_W:0]    bot_rd_slot;
  logic [REC_W-1:0]  top_rd_slot;
  logic [IDX_W-1:0]  rd_addr, wr_addr, ram_addr;
  logic              ram_we;
  logic [OFS_W-1:0]  hdr_rdata;
  logic [OFS_W-1:0]  clamp;

  // Header store: read at command capture, written when an allocation lands.
  desa_ram #(
    .WIDTH (OFS_W),
    .DEPTH (MAX_RECORDS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (cmd_i.accept),
    .addr_i  (ram_addr),
    .wdata_i (size_q),
    .rdata_o (hdr_rdata)
  );

  // Read address: the record below the popped top one, or the popped
  // bottom one, which sits at MAX_RECORDS minus the bottom count.
  assign top_rd_slot = tr_q - REC_W'(2);
  assign bot_rd_slot = MAX_REC - {1'b0, br_q};
  assign rd_addr = (func_i == FUNC_FREE_BOTTOM) ? bot_rd_slot[IDX_W-1:0]
                                               : top_rd_slot[IDX_W-1:0];
  assign wr_addr = (func_q == FUNC_ALLOC_BOTTOM) ? (LAST_IDX - br_q[IDX_W-1:0])
                                                : tr_q[IDX_W-1:0];
  assign ram_addr = cmd_i.accept ? rd_addr : wr_addr;

  // Fit tests for the two allocation directions.
  assign need     = {1'b0, size_q} + HDR_EXT;
  assign gap      = bot_q - top_q;
  assign rec_sum  = {1'b0, tr_q} + {1'b0, br_q};
  assign room     = rec_sum < MAX_REC;
  assign fits_top = room && (({1'b0, top_q} + need) <= {1'b0, bot_q});
  assign fits_bot = room && (need <= {1'b0, gap});

  // Command execution.
  always_comb begin
    top_d  = top_q;
    bot_d  = bot_q;
    tblk_d = tblk_q;
    tr_d   = tr_q;
    br_d   = br_q;
    ok_d   = 1'b0;
    blk_d  = '0;
    ram_we = 1'b0;
    unique case (func_q)
      FUNC_ALLOC_TOP: begin
        if (fits_top) begin
          ok_d   = 1'b1;
          blk_d  = top_q;
          tblk_d = top_q;
          top_d  = top_q + need[OFS_W-1:0];
          tr_d   = tr_q + REC_W'(1);
          ram_we = cmd_i.execute;
        end
      end
      FUNC_ALLOC_BOTTOM: begin
        if (fits_bot) begin
          ok_d   = 1'b1;
          blk_d  = bot_q - size_q;
          bot_d  = bot_q - need[OFS_W-1:0];
          br_d   = br_q + REC_W'(1);
          ram_we = cmd_i.execute;
        end
      end
      FUNC_FREE_TOP: begin
        if (tr_q != '0) begin
          ok_d   = 1'b1;
          top_d  = tblk_q;
          tblk_d = tblk_q - HDR_OFS - hdr_rdata;
          tr_d   = tr_q - REC_W'(1);
        end
      end
      FUNC_FREE_BOTTOM: begin
        if (br_q != '0) begin
          ok_d  = 1'b1;
          bot_d = bot_q + hdr_rdata + HDR_OFS;
          br_d  = br_q - REC_W'(1);
        end
      end
      FUNC_CLEAR_TOP: begin
        top_d = '0;
        tr_d  = '0;
      end
      FUNC_CLEAR_BOTTOM: begin
        bot_d = arena_q;
        br_d  = '0;
      end
      default: begin
      end
    endcase
  end

  // Register write value, held within the supported arena sizes.
  always_comb begin
    clamp = cfg_wdata_i;
    if (cfg_wdata_i < ARENA_MIN) begin
      clamp = ARENA_MIN;
    end else if (cfg_wdata_i > ARENA_RST) begin
      clamp = ARENA_RST;
    end
  end
  assign arena_d = cfg_we_i ? clamp : arena_q;

  // Allocator state; a register write clears both stacks.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arena_q <= ARENA_RST;
      top_q   <= '0;
      bot_q   <= ARENA_RST;
      tblk_q  <= '0;
      tr_q    <= '0;
      br_q    <= '0;
    end else if (cfg_we_i) begin
      arena_q <= arena_d;
      top_q   <= '0;
      bot_q   <= arena_d;
      tblk_q  <= '0;
      tr_q    <= '0;
      br_q    <= '0;
    end else if (cmd_i.execute) begin
      top_q  <= top_d;
      bot_q  <= bot_d;
      tblk_q <= tblk_d;
      tr_q   <= tr_d;
      br_q   <= br_d;
    end
  end

  // Captured command and result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= func_i;
      size_q <= alloc_size_i;
    end
    if (cmd_i.execute) begin
      ok_q   <= ok_d;
      blk_q  <= blk_d;
      topb_q <= (tr_d == '0) ? '0 : tblk_d;
      botb_q <= (br_d == '0) ? bot_d : (bot_d + HDR_OFS);
    end
  end

  assign arena_o        = arena_q;
  assign ok_o           = ok_q;
  assign block_offset_o = blk_q;
  assign top_block_o    = topb_q;
  assign bottom_block_o = botb_q;

endmodule
